[hw/rtl/ftppc_pkg.sv]
// Shared types and constants for the FTP PORT command parser.
// No dependencies; used by every module of the parser.
package ftppc_pkg;

  localparam int unsigned PositionBitsDef = 16;

  localparam logic [7:0] ChrP     = 8'h70;
  localparam logic [7:0] ChrO     = 8'h6F;
  localparam logic [7:0] ChrR     = 8'h72;
  localparam logic [7:0] ChrT     = 8'h74;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrComma = 8'h2C;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] CaseBit  = 8'h20;

  localparam logic [2:0] LastNumIdx = 3'd5;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic        is_port_command;
    logic [31:0] data_address;
    logic [15:0] data_port;
    logic [15:0] argument_offset;
    logic [15:0] argument_length;
  } result_t;

endpackage

[hw/rtl/ftppc_in_stage.sv]
// Input register of the FTP PORT command parser.
// Depends on ftppc_pkg for the input word type.
module ftppc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  ftppc_pkg::in_word_t word_i,
  input  logic               take_i,
  output logic               valid_o,
  output ftppc_pkg::in_word_t word_o
);

  logic               valid_q;
  logic               valid_d;
  ftppc_pkg::in_word_t word_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

[hw/rtl/ftppc_parse.sv]
// Parser state and per-byte next-state logic of the FTP PORT command parser.
// Depends on ftppc_pkg for character constants and the result type.
module ftppc_parse #(
  parameter int unsigned POSITION_BITS = ftppc_pkg::PositionBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  ftppc_pkg::in_word_t word_i,
  output logic                res_valid_o,
  output ftppc_pkg::result_t  res_o
);

  localparam logic [3:0] PhP    = 4'd0;
  localparam logic [3:0] PhO    = 4'd1;
  localparam logic [3:0] PhR    = 4'd2;
  localparam logic [3:0] PhT    = 4'd3;
  localparam logic [3:0] PhSp   = 4'd4;
  localparam logic [3:0] PhSkip = 4'd5;
  localparam logic [3:0] PhNum  = 4'd6;
  localparam logic [3:0] PhDone = 4'd7;
  localparam logic [3:0] PhFail = 4'd8;

  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  logic [3:0]               phase_q, phase_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] arg_q, arg_d;
  logic [2:0]               idx_q, idx_d;
  logic [8:0]               cur_q, cur_d;
  logic [47:0]              asm_q, asm_d;

  logic [7:0]  b;
  logic [7:0]  lc;
  logic        is_digit;
  logic        is_term;
  logic        num_ctx;
  logic [11:0] num_calc;
  logic [POSITION_BITS-1:0] len_full;
  logic [31:0] arg_wide;
  logic [31:0] len_wide;
  logic        ok;

  assign b        = word_i.payload_byte;
  assign lc       = b | ftppc_pkg::CaseBit;
  assign is_digit = (b >= ftppc_pkg::ChrZero) && (b <= ftppc_pkg::ChrNine);
  assign is_term  = (b == ftppc_pkg::ChrCr) || (b == ftppc_pkg::ChrLf);
  assign num_calc = {3'b000, cur_q} * 12'd10 + {8'h00, b[3:0]};
  assign num_ctx  = (phase_q == PhNum) ||
                    ((phase_q == PhSkip) && (b != ftppc_pkg::ChrSpace));

  always_comb begin
    phase_d = phase_q;
    arg_d   = arg_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    asm_d   = asm_q;
    case (phase_q)
      PhP:    phase_d = (lc == ftppc_pkg::ChrP) ? PhO : PhFail;
      PhO:    phase_d = (lc == ftppc_pkg::ChrO) ? PhR : PhFail;
      PhR:    phase_d = (lc == ftppc_pkg::ChrR) ? PhT : PhFail;
      PhT:    phase_d = (lc == ftppc_pkg::ChrT) ? PhSp : PhFail;
      PhSp:   phase_d = (b == ftppc_pkg::ChrSpace) ? PhSkip : PhFail;
      PhSkip: begin
        if (num_ctx) begin
          arg_d   = pos_q;
          phase_d = PhNum;
        end
      end
      PhNum:  phase_d = PhNum;
      PhDone: phase_d = PhDone;
      default: phase_d = PhFail;
    endcase
    if (num_ctx) begin
      if (is_digit) begin
        cur_d = num_calc[8:0];
        if (num_calc >= 12'd256) begin
          phase_d = PhFail;
        end
      end else if (b == ftppc_pkg::ChrComma) begin
        if (idx_q >= ftppc_pkg::LastNumIdx) begin
          phase_d = PhFail;
        end else begin
          asm_d = {asm_q[39:0], cur_q[7:0]};
          cur_d = 9'd0;
          idx_d = idx_q + 3'd1;
        end
      end else if (is_term && (idx_q == ftppc_pkg::LastNumIdx)) begin
        asm_d   = {asm_q[39:0], cur_q[7:0]};
        cur_d   = 9'd0;
        phase_d = PhDone;
      end else begin
        phase_d = PhFail;
      end
    end
    pos_d = pos_q;
    if ((phase_d != PhDone) && (pos_q != PosMax)) begin
      pos_d = pos_q + 1'b1;
    end
  end

  assign ok       = (phase_d == PhDone);
  assign len_full = pos_d - arg_d;
  assign arg_wide = 32'(arg_d);
  assign len_wide = 32'(len_full);

  assign res_valid_o           = take_i && word_i.is_last;
  assign res_o.is_port_command = ok;
  assign res_o.data_address    = ok ? asm_d[47:16] : 32'd0;
  assign res_o.data_port       = ok ? asm_d[15:0] : 16'd0;
  assign res_o.argument_offset = ok ? arg_wide[15:0] : 16'd0;
  assign res_o.argument_length = ok ? len_wide[15:0] : 16'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhP;
      pos_q   <= '0;
      arg_q   <= '0;
      idx_q   <= 3'd0;
      cur_q   <= 9'd0;
      asm_q   <= 48'd0;
    end else if (take_i) begin
      if (word_i.is_last) begin
        phase_q <= PhP;
        pos_q   <= '0;
        arg_q   <= '0;
        idx_q   <= 3'd0;
        cur_q   <= 9'd0;
        asm_q   <= 48'd0;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        arg_q   <= arg_d;
        idx_q   <= idx_d;
        cur_q   <= cur_d;
        asm_q   <= asm_d;
      end
    end
  end

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && word_i.is_last |=> phase_q == PhP && pos_q == '0)
    else $error("Parser did not restart after the last word of a payload.");

  a_pos_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(take_i && word_i.is_last) |=> pos_q >= $past(pos_q))
    else $error("Byte position moved backward within a payload.");

  a_done_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDone |-> idx_q == ftppc_pkg::LastNumIdx)
    else $error("Command completed before the sixth number.");

  a_arg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhNum || phase_q == PhDone |-> arg_q <= pos_q)
    else $error("Argument start lies beyond the byte position.");

endmodule

[hw/rtl/ftppc_out_stage.sv]
// Result register of the FTP PORT command parser.
// Depends on ftppc_pkg for the result type.
module ftppc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ftppc_pkg::result_t res_i,
  output logic               free_o,
  output logic               valid_o,
  input  logic               ready_i,
  output ftppc_pkg::result_t res_o
);

  logic               valid_q;
  logic               valid_d;
  ftppc_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

[hw/rtl/ftp_port_command_parser.sv]
// FTP PORT command parser top level: input register, parser, result register.
// The result of a payload is formed as its last word leaves the input register and is then held in the result register.
// Throughput: one word per cycle, except while a last word waits for the result register.
// A last word waits in the input register only while the result register is full.
// Reset clears the handshake state and returns the parser to the start of a payload.
// Depends on ftppc_pkg, ftppc_in_stage, ftppc_parse and ftppc_out_stage.
module ftp_port_command_parser #(
  parameter int unsigned POSITION_BITS = ftppc_pkg::PositionBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] payload_byte
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] data_address, [47:32] data_port, [63:48] argument_offset,
  // [79:64] argument_length
  output logic [79:0] m_axis_tdata_o,
  // [0] is_port_command
  output logic        m_axis_tuser_o
);

  ftppc_pkg::in_word_t in_word;
  ftppc_pkg::in_word_t stage_word;
  ftppc_pkg::result_t  parse_res;
  ftppc_pkg::result_t  out_res;
  logic                stage_valid;
  logic                take;
  logic                out_free;
  logic                res_valid;

  assign in_word.payload_byte = s_axis_tdata_i;
  assign in_word.is_last      = s_axis_tlast_i;

  assign take = stage_valid && (!stage_word.is_last || out_free);

  ftppc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .word_i  (in_word),
    .take_i  (take),
    .valid_o (stage_valid),
    .word_o  (stage_word)
  );

  ftppc_parse #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .word_i      (stage_word),
    .res_valid_o (res_valid),
    .res_o       (parse_res)
  );

  ftppc_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (parse_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {out_res.argument_length, out_res.argument_offset,
                           out_res.data_port, out_res.data_address};
  assign m_axis_tuser_o = out_res.is_port_command;

endmodule
